// ===== hdl/cia_pkg.sv =====
// package: types and codes shared by the checked integer alu
`timescale 1ns / 1ps
`default_nettype none
package cia_pkg;

	localparam int unsigned OP_W = 3;
	localparam int unsigned PORT_W = 64;

	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_POW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PORT_W-1:0] left_operand;
		logic [PORT_W-1:0] right_operand;
	} in_item_t;

	typedef struct packed {
		logic [PORT_W-1:0] value;
		logic              refused;
	} out_item_t;

endpackage
`default_nettype wire

// ===== hdl/checked_int64_alu.sv =====
// top level: overflow-checked signed integer alu
//
// One operation per transaction on the in channel (op and two signed
// operands); exactly one transaction leaves on the out channel with the
// value and a refused flag. Refused results carry value zero.
// Operands use the low DATA_WIDTH bits, sign-extended; results come out
// sign-extended to 64 bits.
// Add, subtract and the immediate cases are registered at acceptance and
// reach out_valid in the next cycle; multiply runs one bit per cycle in
// the shared shift-add unit; divide yields one quotient bit per cycle;
// power repeats the multiply up to DATA_WIDTH times, stopping on the
// first overflow.
// One operation at a time: in_ready is low from acceptance until the result
// is taken. A stalled receiver holds the result in the output register.
// Reset clears the sequencer; no transaction is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none
module checked_int64_alu #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cia_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output cia_pkg::out_item_t      out_item
);
	import cia_pkg::*;

	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned CW = $clog2(W + 1);
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE  = W'(1);

	state_t state_q, state_d;

	logic [W-1:0]    res_q;
	logic            ref_q;
	logic            neg_q;
	logic [W-1:0]    acc_q;
	logic [W-1:0]    exp_q;
	logic [W-1:0]    ma_q;
	logic [W-1:0]    mb_q;
	logic [W-1:0]    rem_q;
	logic [W-1:0]    quo_q;
	logic [CW-1:0]   cnt_q;
	logic            mul_start;

	logic [W-1:0] a_in, b_in;
	logic         a_neg, b_neg;
	logic [W-1:0] abs_a, abs_b;
	logic [W:0]   add_full, sub_full;
	logic         add_ovf, sub_ovf;

	logic         mul_busy, mul_done, mul_ovf;
	logic [W-1:0] mul_prod;
	logic [W-1:0] mul_mb;

	logic [W:0]   rem_sh;
	logic         rem_ge;
	logic [W-1:0] mul_res;
	logic         mul_bad;

	assign a_in  = in_item.left_operand[W-1:0];
	assign b_in  = in_item.right_operand[W-1:0];
	assign a_neg = a_in[W-1];
	assign b_neg = b_in[W-1];
	assign abs_a = a_neg ? (~a_in + ONE) : a_in;
	assign abs_b = b_neg ? (~b_in + ONE) : b_in;

	assign add_full = {a_in[W-1], a_in} + {b_in[W-1], b_in};
	assign sub_full = {a_in[W-1], a_in} - {b_in[W-1], b_in};
	assign add_ovf  = add_full[W] != add_full[W-1];
	assign sub_ovf  = sub_full[W] != sub_full[W-1];

	// multiply in power mode uses the accumulator magnitude
	assign mul_mb = (state_q == ST_POW) ? acc_q : mb_q;

	cia_mul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mag_a  (ma_q),
		.mag_b  (mul_mb),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (mul_prod),
		.ovf    (mul_ovf)
	);

	// signed result of magnitude product
	always_comb begin
		mul_bad = mul_ovf;
		mul_res = neg_q ? (~mul_prod + ONE) : mul_prod;
		if (!mul_ovf) begin
			if (neg_q) begin
				if (mul_prod > MINV)
					mul_bad = 1'b1;
			end else if (mul_prod[W-1]) begin
				mul_bad = 1'b1;
			end
		end
	end

	assign rem_sh = {rem_q, quo_q[W-1]};
	assign rem_ge = rem_sh >= {1'b0, mb_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_item.op)
						OP_MUL:  state_d = (a_in == '0 || b_in == '0) ? ST_DONE : ST_MUL;
						OP_DIV:  state_d = (b_in == '0 || (a_in == MINV && b_in == '1))
								? ST_DONE : ST_DIV;
						OP_POW: begin
							if (b_neg || b_in == '0 || a_in == '0 || a_in == ONE
									|| a_in == '1)
								state_d = ST_DONE;
							else
								state_d = ST_POW;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_MUL: if (mul_done) state_d = ST_DONE;
			ST_DIV: if (cnt_q == CW'(1)) state_d = ST_DONE;
			ST_POW: begin
				if (mul_done && (mul_bad || exp_q == ONE))
					state_d = ST_DONE;
			end
			ST_DONE: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_DONE);
		out_item.value   = PORT_W'($signed(res_q));
		out_item.refused = ref_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mul_start <= 1'b0;
		end else begin
			state_q   <= state_d;
			mul_start <= 1'b0;
			if (state_q == ST_IDLE && in_valid &&
					(state_d == ST_MUL || state_d == ST_POW))
				mul_start <= 1'b1;
			if (state_q == ST_POW && mul_done && state_d == ST_POW)
				mul_start <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ma_q  <= abs_a;
			mb_q  <= abs_b;
			acc_q <= ONE;
			exp_q <= b_in;
			rem_q <= '0;
			quo_q <= abs_a;
			cnt_q <= CW'(W);
			neg_q <= a_neg ^ b_neg;
			res_q <= '0;
			ref_q <= 1'b0;
			case (in_item.op)
				OP_ADD: begin
					res_q <= add_ovf ? '0 : add_full[W-1:0];
					ref_q <= add_ovf;
				end
				OP_SUB: begin
					res_q <= sub_ovf ? '0 : sub_full[W-1:0];
					ref_q <= sub_ovf;
				end
				OP_MUL: ;
				OP_DIV: begin
					if (b_in == '0 || (a_in == MINV && b_in == '1))
						ref_q <= 1'b1;
				end
				OP_POW: begin
					if (b_neg)
						ref_q <= 1'b1;
					else if (b_in == '0)
						res_q <= ONE;
					else if (a_in == ONE)
						res_q <= ONE;
					else if (a_in == '1)
						res_q <= b_in[0] ? '1 : ONE;
					else if (a_in == '0)
						res_q <= '0;
					// power sign: odd exponent of a negative base
					neg_q <= a_neg & b_in[0];
				end
				default: ref_q <= 1'b1;
			endcase
		end else begin
			case (state_q)
				ST_MUL: begin
					if (mul_done) begin
						res_q <= mul_bad ? '0 : mul_res;
						ref_q <= mul_bad;
					end
				end
				ST_DIV: begin
					quo_q <= {quo_q[W-2:0], rem_ge};
					rem_q <= rem_ge ? W'(rem_sh - {1'b0, mb_q}) : rem_sh[W-1:0];
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						res_q <= neg_q ? (~{quo_q[W-2:0], rem_ge} + ONE)
								: {quo_q[W-2:0], rem_ge};
					end
				end
				ST_POW: begin
					if (mul_done) begin
						acc_q <= mul_prod;
						exp_q <= exp_q - ONE;
						if (mul_bad) begin
							res_q <= '0;
							ref_q <= 1'b1;
						end else if (exp_q == ONE) begin
							// sign of final power applied here
							res_q <= neg_q ? (~mul_prod + ONE) : mul_prod;
						end
					end
				end
				default: ;
			endcase
		end
	end

	ast_done_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.refused |-> out_item.value == '0)
		else $error("refused result with nonzero value");
	ast_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while result pending");
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	ast_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mul_busy)
		else $error("multiplier busy while idle");
endmodule
`default_nettype wire

// ===== hdl/cia_mul.sv =====
// shift-add multiplier on magnitudes, one bit per cycle, with overflow tracking
`timescale 1ns / 1ps
`default_nettype none
module cia_mul #(
	parameter int unsigned W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] mag_a,
	input  wire logic [W-1:0] mag_b,
	output logic              busy,
	output logic              done,
	output logic [W-1:0]      prod,
	output logic              ovf
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  mc_q;
	logic [W-1:0]  mp_q;
	logic          ovf_q;
	logic          mc_hi_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    sum;

	assign sum = {1'b0, acc_q} + {1'b0, mc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mc_q    <= mag_a;
			mp_q    <= mag_b;
			ovf_q   <= 1'b0;
			mc_hi_q <= 1'b0;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				if (mc_hi_q || sum[W])
					ovf_q <= 1'b1;
				acc_q <= sum[W-1:0];
			end
			mc_hi_q <= mc_hi_q || mc_q[W-1];
			mc_q    <= {mc_q[W-2:0], 1'b0};
			mp_q    <= {1'b0, mp_q[W-1:1]};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;
	assign ovf  = ovf_q;
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// testbench: directed table with listed results; random operations checked against a 64-bit predictor
`timescale 1ns / 1ps
module tb;
	import cia_pkg::*;

	localparam longint MAXV = 64'sh7fffffffffffffff;
	localparam longint MINV = 64'sh8000000000000000;
	localparam int N_DIR = 25;
	localparam int N_RAND = 1600;
	localparam logic [OP_W-1:0] OP_BAD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_BAD7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	out_item_t alu_results[$];
	int errors = 0;
	int n_sent = 0;
	int n_got = 0;
	int n_refused = 0;
	bit done_sending = 1'b0;

	typedef struct {
		logic [OP_W-1:0] op;
		longint a;
		longint b;
		bit known;
		longint v;
		bit r;
	} dir_row_t;
	dir_row_t dir_rows[N_DIR];

	checked_int64_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always #1 clk = ~clk;

	function automatic bit mul_fits(longint a, longint b, output longint p);
		longint q;
		p = 0;
		if (a == 0 || b == 0) return 1'b1;
		if (a == -1) begin
			p = -b;
			return b != MINV;
		end
		if (b == -1) begin
			p = -a;
			return a != MINV;
		end
		p = a * b;
		q = p / b;
		return q == a;
	endfunction

	function automatic out_item_t alu_predict(in_item_t it);
		longint a, b, r, acc, s;
		bit bad;
		out_item_t res;
		a = it.left_operand;
		b = it.right_operand;
		r = 0;
		bad = 1'b0;
		case (it.op)
			OP_ADD: begin
				s = a + b;
				bad = (a[63] == b[63]) && (s[63] != a[63]);
				r = s;
			end
			OP_SUB: begin
				s = a - b;
				bad = (a[63] != b[63]) && (s[63] != a[63]);
				r = s;
			end
			OP_MUL: bad = !mul_fits(a, b, r);
			OP_DIV: begin
				if (b == 0 || (a == MINV && b == -1)) bad = 1'b1;
				else r = a / b;
			end
			OP_POW: begin
				if (b < 0) bad = 1'b1;
				else if (b == 0) r = 1;
				else if (a == 0 || a == 1) r = a;
				else if (a == -1) r = b[0] ? -1 : 1;
				else begin
					acc = 1;
					for (longint k = 0; k < b && !bad; k++) begin
						bad = !mul_fits(acc, a, s);
						acc = s;
					end
					r = acc;
				end
			end
			default: bad = 1'b1;
		endcase
		res.value = bad ? '0 : r;
		res.refused = bad;
		return res;
	endfunction

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
			($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic send_op(in_item_t it, bit known, out_item_t exp_res);
		alu_results.push_back(known ? exp_res : alu_predict(it));
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_sent++;
		@(negedge clk);
		idle_gap();
	endtask

	function automatic longint rand_operand();
		longint v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(0, 7))
			0: return v;
			1: return MAXV - $urandom_range(0, 3);
			2: return MINV + $urandom_range(0, 3);
			3: return $signed($urandom_range(0, 8)) - 4;
			4: return v >>> $urandom_range(0, 63);
			5: return $signed(v[31:0]);
			default: return $signed(v[15:0]);
		endcase
	endfunction

	initial begin
		in_item_t it;
		out_item_t er;
		dir_rows = '{
			'{OP_ADD, MAXV, 1, 1, 0, 1},
			'{OP_ADD, MINV, -1, 1, 0, 1},
			'{OP_ADD, MAXV, MINV, 1, -1, 0},
			'{OP_SUB, MINV, 1, 1, 0, 1},
			'{OP_SUB, MAXV, -1, 1, 0, 1},
			'{OP_SUB, 0, MINV, 1, 0, 1},
			'{OP_MUL, MINV, -1, 1, 0, 1},
			'{OP_MUL, -1, MINV, 1, 0, 1},
			'{OP_MUL, MAXV, -1, 1, MINV + 1, 0},
			'{OP_MUL, 64'sh100000000, 64'sh80000000, 1, 0, 1},
			'{OP_MUL, -64'sh100000000, 64'sh80000000, 1, MINV, 0},
			'{OP_DIV, 7, 0, 1, 0, 1},
			'{OP_DIV, MINV, -1, 1, 0, 1},
			'{OP_DIV, -7, 2, 1, -3, 0},
			'{OP_DIV, MINV, 1, 1, MINV, 0},
			'{OP_POW, 0, 0, 1, 1, 0},
			'{OP_POW, 5, -1, 1, 0, 1},
			'{OP_POW, 1, -3, 1, 0, 1},
			'{OP_POW, -1, MAXV, 1, -1, 0},
			'{OP_POW, 0, MAXV, 1, 0, 0},
			'{OP_POW, -2, 63, 1, MINV, 0},
			'{OP_POW, 2, 63, 1, 0, 1},
			'{OP_POW, 3, MAXV, 1, 0, 1},
			'{OP_BAD5, 1, 1, 1, 0, 1},
			'{OP_BAD7, MAXV, MINV, 1, 0, 1}
		};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		foreach (dir_rows[i]) begin
			it.op = dir_rows[i].op;
			it.left_operand = dir_rows[i].a;
			it.right_operand = dir_rows[i].b;
			er.value = dir_rows[i].v;
			er.refused = dir_rows[i].r;
			send_op(it, dir_rows[i].known, er);
		end
		for (int i = 0; i < N_RAND; i++) begin
			it.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) :
				3'($urandom_range(0, 4));
			it.left_operand = rand_operand();
			it.right_operand = rand_operand();
			if (it.op == OP_POW && $urandom_range(0, 2) != 0)
				it.right_operand = $signed($urandom_range(0, 70)) - 2;
			send_op(it, 1'b0, er);
		end
		in_valid <= 1'b0;
		done_sending = 1'b1;
	end

	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else if ($urandom_range(0, 19) == 0) out_ready <= 1'b0;
		else if ($urandom_range(0, 2) != 0) out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			n_got++;
			if (alu_results.size() == 0) begin
				$display("%0t: unexpected result value=%h refused=%b", $time,
					out_item.value, out_item.refused);
				errors++;
			end else begin
				want = alu_results.pop_front();
				if (out_item.refused) n_refused++;
				if (out_item.value !== want.value) begin
					$display("%0t: value mismatch expected %h actual %h", $time,
						want.value, out_item.value);
					errors++;
				end
				if (out_item.refused !== want.refused) begin
					$display("%0t: refused mismatch expected %b actual %b", $time,
						want.refused, out_item.refused);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (done_sending && alu_results.size() == 0);
		repeat (200) @(posedge clk);
		$display("sent %0d operations, got %0d results (%0d refused)",
			n_sent, n_got, n_refused);
		if (errors == 0 && alu_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#100ms;
		$display("timeout");
		$display("Simulation FAILED");
		$finish;
	end
endmodule
